[rtl/sopaf_pkg.sv]
// shared types, constants and arithmetic helpers for the second-order allpass filter
`default_nettype none

package sopaf_pkg;

  localparam int CHANNELS     = 16;
  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 24;
  localparam int COEF_FRAC    = 22;
  localparam int CHAN_WIDTH   = 4;

  localparam int CHAN_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DIFF_W  = SAMPLE_WIDTH + 1;
  localparam int PROD_W  = COEF_WIDTH + DIFF_W;
  localparam int RND_W   = PROD_W - COEF_FRAC;
  localparam int SUM_W   = RND_W + 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COEF_WIDTH;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_SECOND = 1'd1;

  localparam int OUT_AW    = 2;
  localparam int OUT_DEPTH = 2 ** OUT_AW;
  localparam int OUT_CNT_W = OUT_AW + 1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [DIFF_W-1:0]       diff_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [RND_W-1:0]        rnd_t;
  typedef logic signed [SUM_W-1:0]        sum_t;
  typedef logic [CHAN_WIDTH-1:0]          chan_t;
  typedef logic [CHAN_AW-1:0]             chan_addr_t;

  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } chan_state_t;

  typedef struct packed {
    sample_t sample;
    chan_t   ch;
  } out_item_t;

  localparam sum_t SUM_MAX = sum_t'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam sum_t SUM_MIN = sum_t'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

  // add half an lsb, then floor shift
  function automatic rnd_t round_prod(prod_t p);
    prod_t t;
    t = p + (prod_t'(1) <<< (COEF_FRAC - 1));
    return rnd_t'(t >>> COEF_FRAC);
  endfunction

  function automatic sample_t sat_sample(sum_t v);
    sample_t r;
    if (v > SUM_MAX) begin
      r = sample_t'(SUM_MAX);
    end else if (v < SUM_MIN) begin
      r = sample_t'(SUM_MIN);
    end else begin
      r = sample_t'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/second_order_allpass_filter.sv]
// multichannel second-order allpass filter with per-channel state memory
// an accepted item passes stages 1, 2 and 3 and the result queue before out_valid
// a new item stalls while one is in stage 1, as stages 1 and 2 share one multiplier
// a 4-entry result queue lets items be accepted while results wait on out_stall
// reset (synchronous, rst_n low) zeros coefficients and clears every channel's state
// via per-channel valid bits, so the block accepts items right after reset
`default_nettype none

module second_order_allpass_filter (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_wr_en,
  input  wire  [sopaf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [sopaf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  sopaf_pkg::sample_t            in_sample_in,
  input  wire  sopaf_pkg::chan_t              in_channel_in,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output sopaf_pkg::sample_t                  out_sample_out,
  output sopaf_pkg::chan_t                    out_channel_out
);

  // configuration
  sopaf_pkg::coef_t coef_first_r;
  sopaf_pkg::coef_t coef_second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_first_r  <= '0;
      coef_second_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sopaf_pkg::REG_COEF_FIRST:  coef_first_r  <= sopaf_pkg::coef_t'(cfg_data);
        sopaf_pkg::REG_COEF_SECOND: coef_second_r <= sopaf_pkg::coef_t'(cfg_data);
      endcase
    end
  end

  // pipeline valids and result queue count
  logic                              v1_r, v2_r, v3_r;
  logic [sopaf_pkg::OUT_CNT_W-1:0]   out_cnt_r;
  logic [sopaf_pkg::OUT_CNT_W-1:0]   used;
  logic                              in_acc;
  logic                              in_ok;

  assign used     = out_cnt_r + sopaf_pkg::OUT_CNT_W'(v1_r) + sopaf_pkg::OUT_CNT_W'(v2_r)
                  + sopaf_pkg::OUT_CNT_W'(v3_r);
  assign in_stall = v1_r | (used >= sopaf_pkg::OUT_CNT_W'(sopaf_pkg::OUT_DEPTH));
  assign in_acc   = in_valid & ~in_stall;
  assign in_ok    = int'(in_channel_in) < sopaf_pkg::CHANNELS;

  // state memory with per-entry valid bits
  sopaf_pkg::chan_state_t   st_mem [sopaf_pkg::CHANNELS];
  logic [sopaf_pkg::CHANNELS-1:0] ent_vld_r;
  sopaf_pkg::chan_state_t   rd_word_r;
  logic                     rd_vld_r;
  sopaf_pkg::chan_addr_t    rd_addr;
  sopaf_pkg::chan_addr_t    wr_addr;
  logic                     wr_en;
  sopaf_pkg::chan_state_t   wr_word;

  assign rd_addr = sopaf_pkg::CHAN_AW'(in_channel_in);

  always_ff @(posedge clk) begin
    rd_word_r <= st_mem[rd_addr];
    rd_vld_r  <= ent_vld_r[rd_addr];
    if (wr_en) begin
      st_mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (wr_en) begin
      ent_vld_r[wr_addr] <= 1'b1;
    end
  end

  // stage 1: resolve state, first product c2*(x - y2)
  sopaf_pkg::sample_t       s1_x_r;
  sopaf_pkg::chan_t         s1_ch_r;
  logic                     s1_ok_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r  <= in_sample_in;
      s1_ch_r <= in_channel_in;
      s1_ok_r <= in_ok;
    end
  end

  // stage 3 and writeback record declarations used by forwarding
  sopaf_pkg::sample_t       s3_x_r, s3_x1_r, s3_x2_r, s3_y1_r;
  sopaf_pkg::chan_t         s3_ch_r;
  logic                     s3_ok_r;
  sopaf_pkg::rnd_t          w2_r;
  sopaf_pkg::chan_state_t   rec_r;
  sopaf_pkg::chan_t         rec_ch_r;
  logic                     rec_vld_r;

  logic                     fwd3;
  logic                     fwdr;
  sopaf_pkg::chan_state_t   s1_st;
  sopaf_pkg::diff_t         d2;

  assign fwd3 = v3_r & s3_ok_r & (s3_ch_r == s1_ch_r);
  assign fwdr = rec_vld_r & (rec_ch_r == s1_ch_r);

  always_comb begin
    s1_st = rd_vld_r ? rd_word_r : '0;
    priority if (fwd3) begin
      s1_st.x1 = s3_x_r;
      s1_st.x2 = s3_x1_r;
      s1_st.y1 = '0;
      s1_st.y2 = s3_y1_r;
    end else if (fwdr) begin
      s1_st = rec_r;
    end
  end

  assign d2 = sopaf_pkg::DIFF_W'(s1_x_r) - sopaf_pkg::DIFF_W'(s1_st.y2);

  // stage 2: second product c1*(x1 - y1)
  sopaf_pkg::sample_t       s2_x_r, s2_x1_r, s2_x2_r, s2_y1_r;
  sopaf_pkg::chan_t         s2_ch_r;
  logic                     s2_ok_r;
  logic                     s2_y1fwd_r;
  sopaf_pkg::sample_t       s2_y1;
  sopaf_pkg::diff_t         d1;

  always_ff @(posedge clk) begin
    if (v1_r) begin
      s2_x_r     <= s1_x_r;
      s2_ch_r    <= s1_ch_r;
      s2_ok_r    <= s1_ok_r;
      s2_x1_r    <= s1_st.x1;
      s2_x2_r    <= s1_st.x2;
      s2_y1_r    <= s1_st.y1;
      s2_y1fwd_r <= fwd3;
    end
  end

  // previous item's fresh output is in the record once this item reaches stage 2
  assign s2_y1 = s2_y1fwd_r ? rec_r.y1 : s2_y1_r;
  assign d1    = sopaf_pkg::DIFF_W'(s2_x1_r) - sopaf_pkg::DIFF_W'(s2_y1);

  // shared multiplier
  sopaf_pkg::coef_t mul_a;
  sopaf_pkg::diff_t mul_b;
  sopaf_pkg::prod_t prod_r;

  assign mul_a = v2_r ? coef_first_r : coef_second_r;
  assign mul_b = v2_r ? d1 : d2;

  always_ff @(posedge clk) begin
    prod_r <= sopaf_pkg::PROD_W'(mul_a) * sopaf_pkg::PROD_W'(mul_b);
  end

  // stage 3: sum, saturate, write back
  always_ff @(posedge clk) begin
    if (v2_r) begin
      s3_x_r  <= s2_x_r;
      s3_ch_r <= s2_ch_r;
      s3_ok_r <= s2_ok_r;
      s3_x1_r <= s2_x1_r;
      s3_x2_r <= s2_x2_r;
      s3_y1_r <= s2_y1;
      w2_r    <= sopaf_pkg::round_prod(prod_r);
    end
  end

  sopaf_pkg::rnd_t    w1;
  sopaf_pkg::sum_t    acc;
  sopaf_pkg::sample_t y_sat;
  sopaf_pkg::sample_t y_res;

  assign w1    = sopaf_pkg::round_prod(prod_r);
  assign acc   = sopaf_pkg::SUM_W'(w1) + sopaf_pkg::SUM_W'(w2_r)
               + sopaf_pkg::SUM_W'(s3_x2_r);
  assign y_sat = sopaf_pkg::sat_sample(acc);
  assign y_res = s3_ok_r ? y_sat : '0;

  assign wr_en   = v3_r & s3_ok_r;
  assign wr_addr = sopaf_pkg::CHAN_AW'(s3_ch_r);

  always_comb begin
    wr_word.x1 = s3_x_r;
    wr_word.x2 = s3_x1_r;
    wr_word.y1 = y_sat;
    wr_word.y2 = s3_y1_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_r    <= wr_word;
      rec_ch_r <= s3_ch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_vld_r <= 1'b0;
    end else if (wr_en) begin
      rec_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // result queue
  sopaf_pkg::out_item_t            q_mem [sopaf_pkg::OUT_DEPTH];
  logic [sopaf_pkg::OUT_AW-1:0]    q_wr_ptr_r;
  logic [sopaf_pkg::OUT_AW-1:0]    q_rd_ptr_r;
  logic                            q_push;
  logic                            q_pop;
  sopaf_pkg::out_item_t            q_head;

  assign q_push = v3_r;
  assign q_pop  = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr_ptr_r] <= '{sample: y_res, ch: s3_ch_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_ptr_r <= '0;
      q_rd_ptr_r <= '0;
      out_cnt_r  <= '0;
    end else begin
      if (q_push) begin
        q_wr_ptr_r <= q_wr_ptr_r + sopaf_pkg::OUT_AW'(1);
      end
      if (q_pop) begin
        q_rd_ptr_r <= q_rd_ptr_r + sopaf_pkg::OUT_AW'(1);
      end
      unique case ({q_push, q_pop})
        2'b10:   out_cnt_r <= out_cnt_r + sopaf_pkg::OUT_CNT_W'(1);
        2'b01:   out_cnt_r <= out_cnt_r - sopaf_pkg::OUT_CNT_W'(1);
        default: out_cnt_r <= out_cnt_r;
      endcase
    end
  end

  assign q_head          = q_mem[q_rd_ptr_r];
  assign out_valid       = out_cnt_r != '0;
  assign out_sample_out  = q_head.sample;
  assign out_channel_out = q_head.ch;

  // checks
  a_mul_shared: assert property (@(posedge clk) disable iff (!rst_n)
    !(v1_r && v2_r))
    else $error("multiplier claimed by two stages");

  a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |=> v2_r ##1 v3_r)
    else $error("item dropped inside pipeline");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && out_cnt_r == sopaf_pkg::OUT_CNT_W'(sopaf_pkg::OUT_DEPTH)))
    else $error("result queue overflow");

  a_record: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (rec_vld_r && rec_ch_r == $past(s3_ch_r)))
    else $error("writeback record not updated");

endmodule

`default_nettype wire
